/* src/hsv_pkg.sv */
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared constants and types of the HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int FIELD_W     = FRAC_BITS + 1;
  localparam int H6_W        = FRAC_BITS + 3;
  localparam int BYTE_W      = 8;
  localparam int IN_FIELDS_W = 3 * FIELD_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 3 * BYTE_W;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int PIPE_STAGES = 3;
  localparam int CAPACITY    = FIFO_DEPTH + PIPE_STAGES;
  localparam int CAP_W       = $clog2(CAPACITY + 1);

  localparam logic [FIELD_W-1:0] ONE_FX = FIELD_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } hsv_sector_e;

  typedef struct packed {
    logic                 grey;
    hsv_sector_e          sector;
    logic [FRAC_BITS-1:0] frac;
    logic [FIELD_W-1:0]   sat;
    logic [FIELD_W-1:0]   val;
  } hsv_item_t;

endpackage

`default_nettype wire

/* src/hsv_front.sv */
// ----------------------------------------------------------------------------
// hsv_front
// Input side: unpacks a sample, clamps saturation and value, wraps hue and
// splits hue times six into sector and fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_front (
  input  wire logic                            s_valid_i,
  output logic                                 s_ready_o,
  input  wire logic [hsv_pkg::IN_TDATA_W-1:0]  s_data_i,
  output logic                                 q_valid_o,
  input  wire logic                            q_ready_i,
  output hsv_pkg::hsv_item_t                   q_item_o
);
  import hsv_pkg::*;

  logic [FIELD_W-1:0]   hue;
  logic [FIELD_W-1:0]   sat_raw;
  logic [FIELD_W-1:0]   val_raw;
  logic [FRAC_BITS-1:0] hue_w;
  logic [H6_W-1:0]      h6;

  assign hue     = s_data_i[FIELD_W-1:0];
  assign sat_raw = s_data_i[2*FIELD_W-1:FIELD_W];
  assign val_raw = s_data_i[3*FIELD_W-1:2*FIELD_W];

  assign hue_w = (hue >= ONE_FX) ? '0 : hue[FRAC_BITS-1:0];
  assign h6    = H6_W'(hue_w) * H6_W'(6);

  always_comb begin
    q_item_o.sat    = (sat_raw > ONE_FX) ? ONE_FX : sat_raw;
    q_item_o.val    = (val_raw > ONE_FX) ? ONE_FX : val_raw;
    q_item_o.grey   = (q_item_o.sat == '0);
    q_item_o.sector = hsv_sector_e'(h6[H6_W-1:FRAC_BITS]);
    q_item_o.frac   = h6[FRAC_BITS-1:0];
  end

  assign q_valid_o = s_valid_i;
  assign s_ready_o = q_ready_i;

endmodule

`default_nettype wire

/* src/hsv_fifo.sv */
// ----------------------------------------------------------------------------
// hsv_fifo
// Short queue of classified samples between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_valid_i,
  output logic                    wr_ready_o,
  input  wire hsv_pkg::hsv_item_t wr_item_i,
  output logic                    rd_valid_o,
  input  wire logic               rd_ready_i,
  output hsv_pkg::hsv_item_t      rd_item_o
);
  import hsv_pkg::*;

  hsv_item_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  push, pop;

  assign wr_ready_o = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_ready_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = push ? FIFO_PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop  ? FIFO_PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = FIFO_CNT_W'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = FIFO_CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

/* src/hsv_back.sv */
// ----------------------------------------------------------------------------
// hsv_back
// Three-stage pipeline: first products and p, then q/t, then sector routing and
// scaling to bytes into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire hsv_pkg::hsv_item_t               in_item_i,
  output logic                                  m_valid_o,
  input  wire logic                             m_ready_i,
  output logic [hsv_pkg::OUT_TDATA_W-1:0]       m_data_o
);
  import hsv_pkg::*;

  function automatic logic [FIELD_W-1:0] fx_mul(input logic [FIELD_W-1:0] a,
                                                input logic [FIELD_W-1:0] b);
    logic [2*FIELD_W-1:0] prod;
    prod = (2*FIELD_W)'(a) * (2*FIELD_W)'(b);
    return prod[FRAC_BITS+FIELD_W-1:FRAC_BITS];
  endfunction

  function automatic logic [BYTE_W-1:0] to_byte(input logic [FIELD_W-1:0] x);
    logic [FIELD_W+BYTE_W-1:0] prod;
    prod = {x, BYTE_W'(0)} - (FIELD_W+BYTE_W)'(x);
    return prod[FRAC_BITS+BYTE_W-1:FRAC_BITS];
  endfunction

  logic               v1_q, v2_q, vo_q;
  logic               en1, en2, eno;

  logic               grey1_q, grey2_q;
  hsv_sector_e        sec1_q, sec2_q;
  logic [FIELD_W-1:0] val1_q, val2_q;
  logic [FIELD_W-1:0] p1_q, p2_q;
  logic [FIELD_W-1:0] sf1_q, snf1_q;
  logic [FIELD_W-1:0] q2_q, t2_q;
  logic [BYTE_W-1:0]  red_q, green_q, blue_q;

  logic [FIELD_W-1:0] r_sel, g_sel, b_sel;

  assign eno        = !vo_q || m_ready_i;
  assign en2        = !v2_q || eno;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;
  assign m_valid_o  = vo_q;
  assign m_data_o   = {blue_q, green_q, red_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (eno) vo_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      grey1_q <= in_item_i.grey;
      sec1_q  <= in_item_i.sector;
      val1_q  <= in_item_i.val;
      p1_q    <= fx_mul(in_item_i.val, ONE_FX - in_item_i.sat);
      sf1_q   <= fx_mul(in_item_i.sat, FIELD_W'(in_item_i.frac));
      snf1_q  <= fx_mul(in_item_i.sat, ONE_FX - FIELD_W'(in_item_i.frac));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      grey2_q <= grey1_q;
      sec2_q  <= sec1_q;
      val2_q  <= val1_q;
      p2_q    <= p1_q;
      q2_q    <= fx_mul(val1_q, ONE_FX - sf1_q);
      t2_q    <= fx_mul(val1_q, ONE_FX - snf1_q);
    end
  end

  always_comb begin
    r_sel = val2_q;
    g_sel = val2_q;
    b_sel = val2_q;
    if (!grey2_q) begin
      case (sec2_q)
        SEC_RED_YELLOW: begin
          r_sel = val2_q; g_sel = t2_q;   b_sel = p2_q;
        end
        SEC_YELLOW_GREEN: begin
          r_sel = q2_q;   g_sel = val2_q; b_sel = p2_q;
        end
        SEC_GREEN_CYAN: begin
          r_sel = p2_q;   g_sel = val2_q; b_sel = t2_q;
        end
        SEC_CYAN_BLUE: begin
          r_sel = p2_q;   g_sel = q2_q;   b_sel = val2_q;
        end
        SEC_BLUE_MAGENTA: begin
          r_sel = t2_q;   g_sel = p2_q;   b_sel = val2_q;
        end
        default: begin
          r_sel = val2_q; g_sel = p2_q;   b_sel = q2_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (eno && v2_q) begin
      red_q   <= to_byte(r_sel);
      green_q <= to_byte(g_sel);
      blue_q  <= to_byte(b_sel);
    end
  end

endmodule

`default_nettype wire

/* src/hsv_to_rgb_converter_top.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV (UQ1.16 fractions) to 8-bit RGB pixel converter.
//
//   channel   dir  width  fields (lsb first)
//   s_axis    in   56     hue[16:0], saturation[33:17], brightness[50:34]
//   m_axis    out  24     red[7:0], green[15:8], blue[23:16]
//
// One transaction per clock sustained while the output is ready; an accepted
// input transaction passes the queue, then the three back stages, to output valid.
// A 4-entry queue separates input classification from the multiply pipeline.
// Output stall holds the pipeline; the queue keeps input open until full.
// Reset clears queue and stage valids only.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // hue[16:0], saturation[33:17], brightness[50:34], zeros[55:51]
  input  wire logic [hsv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [hsv_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import hsv_pkg::*;

  logic      fq_valid, fq_ready;
  hsv_item_t fq_item;
  logic      qb_valid, qb_ready;
  hsv_item_t qb_item;

  hsv_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .q_valid_o (fq_valid),
    .q_ready_i (fq_ready),
    .q_item_o  (fq_item)
  );

  hsv_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_item_i  (fq_item),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_item_o  (qb_item)
  );

  hsv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (qb_valid),
    .in_ready_o (qb_ready),
    .in_item_i  (qb_item),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* src/hsv_checker.sv */
// ----------------------------------------------------------------------------
// hsv_checker
// Port-level checks of the converter: output stall behavior and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [hsv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import hsv_pkg::*;

  logic [CAP_W-1:0] pend_q;
  logic             in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= CAP_W'(pend_q + 1'b1);
    end else if (out_acc && !in_acc) begin
      pend_q <= CAP_W'(pend_q - 1'b1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction dropped or changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != '0)
    else $error("output valid without a pending input transaction");

  a_cap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= CAP_W'(CAPACITY))
    else $error("more transactions in flight than storage holds");

  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == CAP_W'(CAPACITY) |-> !s_axis_tready)
    else $error("input ready while all storage is occupied");

endmodule

bind hsv_to_rgb_converter_top hsv_checker u_hsv_checker (.*);

`default_nettype wire

/* bench/tb_hsv_to_rgb_converter_top.sv */
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_top
// Self-checking bench for the HSV to RGB pixel converter. Directed samples
// hit sector edges, hue wrap, grey and clamped fractions. One long output
// hold-off that fills the block follows, then random bursts under random output
// stalls and full drains. Every pixel is checked channel by channel against
// a fixed-point prediction made when its sample transaction is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hsv_to_rgb_converter_top;
  import hsv_pkg::*;

  localparam logic [63:0] UNITY      = 64'd1 << FRAC_BITS;
  localparam int          NUM_RANDOM = 700;
  localparam int          LONG_HOLD  = 80;
  localparam int          DRAIN_MAX  = 10000;

  class pixel_checker;
    logic [OUT_TDATA_W-1:0] expected_pixels[$];
    int                     errors;
    int                     samples;
    int                     pixels;
    int                     greys;

    function new();
      errors  = 0;
      samples = 0;
      pixels  = 0;
      greys   = 0;
    endfunction

    function logic [BYTE_W-1:0] to_channel(logic [63:0] x);
      logic [63:0] c;
      c = (x * 64'd255) >> FRAC_BITS;
      return (c > 64'd255) ? 8'd255 : c[BYTE_W-1:0];
    endfunction

    function logic [OUT_TDATA_W-1:0] hsv_to_rgb(logic [FIELD_W-1:0] h_in,
                                                 logic [FIELD_W-1:0] s_in,
                                                 logic [FIELD_W-1:0] v_in);
      logic [63:0] hue, sat, val, h6, frac, p, q, t, r, g, b;
      hsv_sector_e sec;
      hue = 64'(h_in);
      sat = (64'(s_in) > UNITY) ? UNITY : 64'(s_in);
      val = (64'(v_in) > UNITY) ? UNITY : 64'(v_in);
      if (sat == 0) begin
        r = val;
        g = val;
        b = val;
      end else begin
        if (hue >= UNITY) begin
          hue = 0;
        end
        h6   = hue * 64'd6;
        sec  = hsv_sector_e'(h6[FRAC_BITS+2:FRAC_BITS]);
        frac = h6 & (UNITY - 1);
        p    = (val * (UNITY - sat)) >> FRAC_BITS;
        q    = (val * (UNITY - ((sat * frac) >> FRAC_BITS))) >> FRAC_BITS;
        t    = (val * (UNITY - ((sat * (UNITY - frac)) >> FRAC_BITS))) >> FRAC_BITS;
        case (sec)
          SEC_RED_YELLOW: begin
            r = val; g = t; b = p;
          end
          SEC_YELLOW_GREEN: begin
            r = q; g = val; b = p;
          end
          SEC_GREEN_CYAN: begin
            r = p; g = val; b = t;
          end
          SEC_CYAN_BLUE: begin
            r = p; g = q; b = val;
          end
          SEC_BLUE_MAGENTA: begin
            r = t; g = p; b = val;
          end
          default: begin
            r = val; g = p; b = q;
          end
        endcase
      end
      return {to_channel(b), to_channel(g), to_channel(r)};
    endfunction

    function void note_sample(logic [IN_TDATA_W-1:0] tdata);
      logic [FIELD_W-1:0] h, s, v;
      h = tdata[FIELD_W-1:0];
      s = tdata[2*FIELD_W-1:FIELD_W];
      v = tdata[3*FIELD_W-1:2*FIELD_W];
      samples++;
      if (s == 0) begin
        greys++;
      end
      expected_pixels.push_back(hsv_to_rgb(h, s, v));
    endfunction

    function void check_pixel(logic [OUT_TDATA_W-1:0] tdata);
      logic [OUT_TDATA_W-1:0] exp_pix;
      string                  names[3];
      names = '{"red", "green", "blue"};
      pixels++;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h", $time, tdata);
        errors++;
        return;
      end
      exp_pix = expected_pixels.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (tdata[BYTE_W*i +: BYTE_W] !== exp_pix[BYTE_W*i +: BYTE_W]) begin
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, names[i],
                   exp_pix[BYTE_W*i +: BYTE_W], tdata[BYTE_W*i +: BYTE_W]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  pixel_checker pix_chk;
  bit           hold_req  = 1'b0;
  int           in_stalls = 0;

  hsv_to_rgb_converter_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Sample at the falling edge, where every signal is settled for the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pix_chk.note_sample(s_axis_tdata);
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        in_stalls++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        pix_chk.check_pixel(m_axis_tdata);
      end
    end
  end

  initial begin
    int mode;
    int left;
    int phase;
    mode  = 0;
    left  = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        phase = (phase + 1) % 7;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= (phase < 3);
        endcase
      end
    end
  end

  task automatic send_sample(input logic [FIELD_W-1:0] h, input logic [FIELD_W-1:0] s,
                             input logic [FIELD_W-1:0] v);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, v, s, h};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_pixels();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pix_chk.expected_pixels.size() != 0);
  endtask

  function automatic logic [FIELD_W-1:0] rand_field();
    case ($urandom_range(0, 9))
      0: return FIELD_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return FIELD_W'(UNITY);
          2: return FIELD_W'(UNITY - 1);
          default: return FIELD_W'(($urandom_range(0, 6) * UNITY) / 6 + $urandom_range(0, 1));
        endcase
      end
      default: return FIELD_W'($urandom_range(0, 32'(UNITY)));
    endcase
  endfunction

  initial begin
    logic [FIELD_W-1:0] one_f;
    logic [FIELD_W-1:0] s;
    int                 sent;
    int                 burst;
    int                 cnt;
    pix_chk = new();
    one_f   = FIELD_W'(UNITY);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < 6; k++) begin
      send_sample(FIELD_W'(((2 * k + 1) * UNITY) / 12), one_f, one_f);
    end
    for (int k = 1; k < 6; k++) begin
      send_sample(FIELD_W'((k * UNITY) / 6), FIELD_W'(UNITY / 2), one_f - 1);
      send_sample(FIELD_W'((k * UNITY + 5) / 6), FIELD_W'(UNITY / 2), one_f - 1);
    end
    send_sample(one_f, one_f, one_f);
    send_sample('1, 17'd40000, 17'd50000);
    send_sample(17'd12345, '0, one_f);
    send_sample(17'd54321, '0, '1);
    send_sample(17'd30000, '1, one_f);
    send_sample(17'd20000, 17'd33333, '0);
    send_sample(one_f - 1, 17'd1, 17'd1);
    drain_pixels();

    // Hold the output off while the input keeps offering, so the block backs up.
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_sample(rand_field(), rand_field(), rand_field());
    end
    drain_pixels();

    sent = 0;
    while (sent < NUM_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < NUM_RANDOM; i++) begin
        s = ($urandom_range(0, 11) == 0) ? '0 : rand_field();
        send_sample(rand_field(), s, rand_field());
        sent++;
      end
      if ($urandom_range(0, 24) == 0) begin
        drain_pixels();
      end else if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 8));
      end
    end

    s_axis_tvalid <= 1'b0;
    cnt = 0;
    do begin
      @(posedge clk_i);
      cnt++;
    end while (pix_chk.expected_pixels.size() != 0 && cnt < DRAIN_MAX);
    repeat (PIPE_STAGES + 8) @(posedge clk_i);
    if (pix_chk.expected_pixels.size() != 0) begin
      $display("%0t: %0d pixels never arrived, expected %h, actual none", $time,
               pix_chk.expected_pixels.size(), pix_chk.expected_pixels[0]);
      pix_chk.errors++;
    end

    $display("Converted %0d HSV samples (%0d grey) into %0d checked pixels.",
             pix_chk.samples, pix_chk.greys, pix_chk.pixels);
    $display("Input was stalled on %0d cycles; %0d channel errors.", in_stalls,
             pix_chk.errors);
    if (pix_chk.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
